// ===== src/kpve_pkg.sv =====
package kpve_pkg;

  typedef struct packed {
    logic signed [31:0] position_measurement;
    logic signed [31:0] velocity_measurement;
    logic signed [31:0] acceleration;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_estimate;
    logic signed [31:0] position_estimate;
  } out_item_t;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_Q_POSITION    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Q_VELOCITY    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_R_POSITION    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_R_VELOCITY    = 3'd4;

  // operations of the shared unit
  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_HALF
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_e;

  // register file slots, 32 of them
  localparam int unsigned SlotW = 5;

  // micro-instruction: op, destination, two sources
  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] dst;
    logic [SlotW-1:0] src_a;
    logic [SlotW-1:0] src_b;
  } uop_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_ctl_t;

endpackage

// ===== src/kalman_pos_vel_estimator_top.sv =====
// Two-state position/velocity Kalman estimator in signed fixed point (default
// Q16.16). Each input transaction (position, velocity, acceleration) runs a
// full predict/update step through one shared arithmetic unit driven by a
// fixed micro-program of 69 operations: saturating add/sub and halving, a
// multiply built from four narrow partial products, and a divide that yields
// one quotient bit per cycle. The program holds 29 multiplies, 4 divides and
// 36 short ops. When it ends the result is written to the output register
// from a hand-off state, and a new input can be taken once the sequencer is
// back in idle. The block is not ready while a step is in flight; a finished
// step waits in the hand-off state only while the output register still
// holds an unaccepted result. Configuration writes are taken at any time and
// should be issued while idle. Output is one transaction per input, values
// clamped to 32 bits.
module kalman_pos_vel_estimator_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kpve_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kpve_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kpve_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned NSLOT = 32;
  localparam int unsigned NUOP  = 68;
  localparam int unsigned PCW   = $clog2(NUOP + 1);
  localparam logic [W-1:0] MAXU = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE  = W'(64'd1 << FRAC_BITS);

  // register file slot map
  localparam logic [kpve_pkg::SlotW-1:0] S_ZP = 5'd0,  S_ZV = 5'd1,  S_AC = 5'd2;
  localparam logic [kpve_pkg::SlotW-1:0] S_DT = 5'd3,  S_QP = 5'd4,  S_QV = 5'd5;
  localparam logic [kpve_pkg::SlotW-1:0] S_RP = 5'd6,  S_RV = 5'd7;
  localparam logic [kpve_pkg::SlotW-1:0] S_XP = 5'd8,  S_XV = 5'd9;
  localparam logic [kpve_pkg::SlotW-1:0] S_P0 = 5'd10, S_P1 = 5'd11, S_P2 = 5'd12;
  localparam logic [kpve_pkg::SlotW-1:0] S_P3 = 5'd13, S_X0 = 5'd14, S_X1 = 5'd15;
  localparam logic [kpve_pkg::SlotW-1:0] S_T0 = 5'd16, S_T1 = 5'd17;
  localparam logic [kpve_pkg::SlotW-1:0] S_A  = 5'd18, S_B  = 5'd19, S_C  = 5'd20;
  localparam logic [kpve_pkg::SlotW-1:0] S_D  = 5'd21, S_HF = 5'd22, S_S0 = 5'd23;
  localparam logic [kpve_pkg::SlotW-1:0] S_S1 = 5'd24, S_DE = 5'd25;
  localparam logic [kpve_pkg::SlotW-1:0] S_K0 = 5'd26, S_K1 = 5'd27, S_K2 = 5'd28;
  localparam logic [kpve_pkg::SlotW-1:0] S_K3 = 5'd29, S_E0 = 5'd30, S_E1 = 5'd31;
  // late temporaries share slots whose last read is already behind them
  localparam logic [kpve_pkg::SlotW-1:0] S_N0 = 5'd16, S_N1 = 5'd17;
  localparam logic [kpve_pkg::SlotW-1:0] S_M0 = 5'd23, S_M1 = 5'd24;
  localparam logic [kpve_pkg::SlotW-1:0] S_M2 = 5'd30, S_M3 = 5'd31;

  // micro-program of one filter step
  function automatic kpve_pkg::uop_t uop(input logic [PCW-1:0] pc);
    kpve_pkg::uop_t u;
    u = '{kpve_pkg::OP_ADD, S_A, S_A, S_A};
    case (pc)
      // acceleration term dt^2/2 * a
      7'd0:  u = '{kpve_pkg::OP_MUL, S_A, S_AC, S_DT};
      7'd1:  u = '{kpve_pkg::OP_MUL, S_A, S_A, S_DT};
      7'd2:  u = '{kpve_pkg::OP_HALF, S_HF, S_A, S_A};
      // predicted state
      7'd3:  u = '{kpve_pkg::OP_MUL, S_A, S_DT, S_XV};
      7'd4:  u = '{kpve_pkg::OP_ADD, S_A, S_XP, S_A};
      7'd5:  u = '{kpve_pkg::OP_ADD, S_X0, S_A, S_HF};
      7'd6:  u = '{kpve_pkg::OP_MUL, S_A, S_DT, S_AC};
      7'd7:  u = '{kpve_pkg::OP_ADD, S_X1, S_XV, S_A};
      // predicted covariance
      7'd8:  u = '{kpve_pkg::OP_MUL, S_A, S_P2, S_DT};
      7'd9:  u = '{kpve_pkg::OP_ADD, S_T0, S_P0, S_A};
      7'd10: u = '{kpve_pkg::OP_MUL, S_A, S_P3, S_DT};
      7'd11: u = '{kpve_pkg::OP_ADD, S_T1, S_P1, S_A};
      7'd12: u = '{kpve_pkg::OP_MUL, S_A, S_T1, S_DT};
      7'd13: u = '{kpve_pkg::OP_ADD, S_A, S_T0, S_A};
      7'd14: u = '{kpve_pkg::OP_ADD, S_P0, S_A, S_QP};
      7'd15: u = '{kpve_pkg::OP_ADD, S_P1, S_T1, S_D};
      7'd16: u = '{kpve_pkg::OP_MUL, S_A, S_P3, S_DT};
      7'd17: u = '{kpve_pkg::OP_ADD, S_P2, S_P2, S_A};
      7'd18: u = '{kpve_pkg::OP_ADD, S_P3, S_P3, S_QV};
      // innovation covariance and determinant
      7'd19: u = '{kpve_pkg::OP_ADD, S_S0, S_P0, S_RP};
      7'd20: u = '{kpve_pkg::OP_ADD, S_S1, S_P3, S_RV};
      7'd21: u = '{kpve_pkg::OP_MUL, S_A, S_S0, S_S1};
      7'd22: u = '{kpve_pkg::OP_MUL, S_B, S_P1, S_P2};
      7'd23: u = '{kpve_pkg::OP_SUB, S_DE, S_A, S_B};
      // gain entries
      7'd24: u = '{kpve_pkg::OP_MUL, S_A, S_P0, S_S1};
      7'd25: u = '{kpve_pkg::OP_SUB, S_A, S_A, S_B};
      7'd26: u = '{kpve_pkg::OP_DIV, S_K0, S_A, S_DE};
      7'd27: u = '{kpve_pkg::OP_MUL, S_A, S_P1, S_S0};
      7'd28: u = '{kpve_pkg::OP_MUL, S_C, S_P0, S_P1};
      7'd29: u = '{kpve_pkg::OP_SUB, S_A, S_A, S_C};
      7'd30: u = '{kpve_pkg::OP_DIV, S_K1, S_A, S_DE};
      7'd31: u = '{kpve_pkg::OP_MUL, S_A, S_P2, S_S1};
      7'd32: u = '{kpve_pkg::OP_MUL, S_C, S_P3, S_P2};
      7'd33: u = '{kpve_pkg::OP_SUB, S_A, S_A, S_C};
      7'd34: u = '{kpve_pkg::OP_DIV, S_K2, S_A, S_DE};
      7'd35: u = '{kpve_pkg::OP_MUL, S_A, S_P3, S_S0};
      7'd36: u = '{kpve_pkg::OP_MUL, S_C, S_P2, S_P1};
      7'd37: u = '{kpve_pkg::OP_SUB, S_A, S_A, S_C};
      7'd38: u = '{kpve_pkg::OP_DIV, S_K3, S_A, S_DE};
      // state correction
      7'd39: u = '{kpve_pkg::OP_SUB, S_E0, S_ZP, S_X0};
      7'd40: u = '{kpve_pkg::OP_SUB, S_E1, S_ZV, S_X1};
      7'd41: u = '{kpve_pkg::OP_MUL, S_A, S_K0, S_E0};
      7'd42: u = '{kpve_pkg::OP_MUL, S_C, S_K1, S_E1};
      7'd43: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd44: u = '{kpve_pkg::OP_ADD, S_N0, S_X0, S_A};
      7'd45: u = '{kpve_pkg::OP_MUL, S_A, S_K2, S_E0};
      7'd46: u = '{kpve_pkg::OP_MUL, S_C, S_K3, S_E1};
      7'd47: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd48: u = '{kpve_pkg::OP_ADD, S_N1, S_X1, S_A};
      // covariance update (I - K) P
      7'd49: u = '{kpve_pkg::OP_MUL, S_A, S_K0, S_P0};
      7'd50: u = '{kpve_pkg::OP_MUL, S_C, S_K1, S_P2};
      7'd51: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd52: u = '{kpve_pkg::OP_SUB, S_M0, S_P0, S_A};
      7'd53: u = '{kpve_pkg::OP_MUL, S_A, S_K0, S_P1};
      7'd54: u = '{kpve_pkg::OP_MUL, S_C, S_K1, S_P3};
      7'd55: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd56: u = '{kpve_pkg::OP_SUB, S_M1, S_P1, S_A};
      7'd57: u = '{kpve_pkg::OP_MUL, S_A, S_K2, S_P0};
      7'd58: u = '{kpve_pkg::OP_MUL, S_C, S_K3, S_P2};
      7'd59: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd60: u = '{kpve_pkg::OP_SUB, S_M2, S_P2, S_A};
      7'd61: u = '{kpve_pkg::OP_MUL, S_A, S_K2, S_P1};
      7'd62: u = '{kpve_pkg::OP_MUL, S_C, S_K3, S_P3};
      7'd63: u = '{kpve_pkg::OP_ADD, S_A, S_A, S_C};
      7'd64: u = '{kpve_pkg::OP_SUB, S_M3, S_P3, S_A};
      // commit new covariance (P = M + 0)
      7'd65: u = '{kpve_pkg::OP_ADD, S_P0, S_M0, S_D};
      7'd66: u = '{kpve_pkg::OP_ADD, S_P1, S_M1, S_D};
      7'd67: u = '{kpve_pkg::OP_ADD, S_P2, S_M2, S_D};
      default: u = '{kpve_pkg::OP_ADD, S_P3, S_M3, S_D};
    endcase
    return u;
  endfunction

  // clamp a 32-bit signed value into the W-bit range
  function automatic logic [W-1:0] clamp_in(input logic signed [31:0] v);
    logic signed [63:0] x;
    logic signed [63:0] mx;
    x  = 64'(v);
    mx = 64'(MAXU);
    if (x > mx) return MAXU;
    if (x < -mx - 64'sd1) return ~MAXU;
    return W'(x);
  endfunction

  function automatic logic [31:0] clamp_out(input logic signed [W-1:0] v);
    logic signed [63:0] x;
    x = 64'(v);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [W-1:0] clamp_u(input logic [31:0] v);
    if (64'(v) > 64'(MAXU)) return MAXU;
    return W'(v);
  endfunction

  kpve_pkg::state_e state_q, state_d;
  logic [PCW-1:0]   pc_q, pc_d;
  logic [W-1:0]     rf_q [NSLOT];
  logic [31:0]      cfg_q [5];
  kpve_pkg::uop_t   cur;
  kpve_pkg::alu_ctl_t ctl;
  logic             alu_done;
  logic signed [W-1:0] alu_res;
  logic             in_acc, out_acc;
  logic             out_load;
  logic             out_valid_q, out_valid_d;
  kpve_pkg::out_item_t out_q, out_d;

  assign cur = uop(pc_q);
  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  kpve_alu #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .a_i   (rf_q[cur.src_a]),
    .b_i   (rf_q[cur.src_b]),
    .done_o(alu_done),
    .res_o (alu_res)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      kpve_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = kpve_pkg::ST_ISSUE;
          pc_d    = '0;
        end
      end
      kpve_pkg::ST_ISSUE: state_d = kpve_pkg::ST_WAIT;
      kpve_pkg::ST_WAIT: begin
        if (alu_done) begin
          if (pc_q == PCW'(NUOP)) begin
            state_d = kpve_pkg::ST_OUT;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = kpve_pkg::ST_ISSUE;
          end
        end
      end
      kpve_pkg::ST_OUT: begin
        // hand the estimates over once the output register is free
        if (out_load) state_d = kpve_pkg::ST_IDLE;
      end
      default: state_d = kpve_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl.start  = (state_q == kpve_pkg::ST_ISSUE);
    ctl.op     = cur.op;
    in_ready_o = (state_q == kpve_pkg::ST_IDLE);
    out_load   = (state_q == kpve_pkg::ST_OUT) && (!out_valid_q || out_acc);
  end

  // output register, frees the sequencer while a result waits
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_acc) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d             = 1'b1;
      out_d.velocity_estimate = clamp_out(rf_q[S_XV]);
      out_d.position_estimate = clamp_out(rf_q[S_XP]);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpve_pkg::ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 32'd131;
      cfg_q[1] <= 32'd655;
      cfg_q[2] <= 32'd655;
      cfg_q[3] <= 32'd327680;
      cfg_q[4] <= 32'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kpve_pkg::REG_SAMPLE_PERIOD: cfg_q[0] <= {16'd0, cfg_data_i[15:0]};
        kpve_pkg::REG_Q_POSITION:    cfg_q[1] <= {1'b0, cfg_data_i[30:0]};
        kpve_pkg::REG_Q_VELOCITY:    cfg_q[2] <= {1'b0, cfg_data_i[30:0]};
        kpve_pkg::REG_R_POSITION:    cfg_q[3] <= {1'b0, cfg_data_i[30:0]};
        kpve_pkg::REG_R_VELOCITY:    cfg_q[4] <= {1'b0, cfg_data_i[30:0]};
        default: ;
      endcase
    end
  end

  // working register file: filter state held in fixed slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) rf_q[i] <= '0;
      rf_q[S_P0] <= ONE;
      rf_q[S_P3] <= ONE;
    end else if (in_acc) begin
      rf_q[S_ZP] <= clamp_in(in_data_i.position_measurement);
      rf_q[S_ZV] <= clamp_in(in_data_i.velocity_measurement);
      rf_q[S_AC] <= clamp_in(in_data_i.acceleration);
      rf_q[S_DT] <= clamp_u(cfg_q[0]);
      rf_q[S_QP] <= clamp_u(cfg_q[1]);
      rf_q[S_QV] <= clamp_u(cfg_q[2]);
      rf_q[S_RP] <= clamp_u(cfg_q[3]);
      rf_q[S_RV] <= clamp_u(cfg_q[4]);
      rf_q[S_D]  <= '0;
    end else if (state_q == kpve_pkg::ST_WAIT && alu_done) begin
      rf_q[cur.dst] <= alu_res;
      if (pc_q == PCW'(NUOP)) begin
        rf_q[S_XP] <= rf_q[S_N0];
        rf_q[S_XV] <= rf_q[S_N1];
      end
    end
  end

  // a result is offered only after the full program ran
  a_out_after_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == kpve_pkg::ST_OUT))
    else $error("result offered before program end");

  // no input taken while a step is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != kpve_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("ready while busy");

  // unit completes only when the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == kpve_pkg::ST_WAIT)
    else $error("unit done outside wait");

endmodule

// ===== src/kpve_alu.sv =====
module kpve_alu #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kpve_pkg::alu_ctl_t           ctl_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned DIVN = W + FRAC_BITS + 1;
  localparam int unsigned CW   = $clog2(DIVN + 1);
  // multiplier is a W/2 by W/2 digit unit, four partial products
  localparam int unsigned HW   = W / 2;
  localparam int unsigned LW   = W - HW;

  localparam logic [W-1:0] MAXU = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MAXV = MAXU;
  localparam logic signed [W-1:0] MINV = ~MAXU;

  logic            busy_q, busy_d;
  kpve_pkg::op_e   op_q, op_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    ma_q, ma_d, mb_q, mb_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [W:0]      rem_q, rem_d;
  logic [DIVN-1:0] num_q, num_d;
  logic [DIVN-1:0] quo_q, quo_d;
  logic            dz_q, dz_d;
  logic            nz_q, nz_d;
  logic            done_q, done_d;
  logic signed [W-1:0] res_q, res_d;

  logic [W-1:0]    abs_a, abs_b;
  logic signed [W:0] sum_w;
  logic [W:0]      rem_sh;
  logic [LW-1:0]   pa, pb;
  logic [W-1:0]    pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   prod_sh;
  logic [W:0]      lim;

  assign abs_a = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign lim   = {1'b0, MAXU} + {{W{1'b0}}, neg_q};
  assign rem_sh = {rem_q[W-1:0], num_q[DIVN-1]};

  // one partial product per cycle, cnt selects digit pair
  always_comb begin
    pa = cnt_q[1] ? LW'(ma_q[W-1:LW]) : ma_q[LW-1:0];
    pb = cnt_q[0] ? LW'(mb_q[W-1:LW]) : mb_q[LW-1:0];
    pp = W'({{LW{1'b0}}, pa} * {{LW{1'b0}}, pb});
    pp_sh = {{W{1'b0}}, pp} << (LW * (32'(cnt_q[1]) + 32'(cnt_q[0])));
    prod_sh = acc_q >> FRAC_BITS;
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    neg_d  = neg_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dz_d   = dz_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    res_d  = res_q;
    sum_w  = '0;
    if (!busy_q && ctl_i.start) begin
      op_d = ctl_i.op;
      unique case (ctl_i.op) inside
        kpve_pkg::OP_ADD, kpve_pkg::OP_SUB: begin
          if (ctl_i.op == kpve_pkg::OP_ADD) begin
            sum_w = {a_i[W-1], a_i} + {b_i[W-1], b_i};
          end else begin
            sum_w = {a_i[W-1], a_i} - {b_i[W-1], b_i};
          end
          if (sum_w[W] != sum_w[W-1]) begin
            res_d = sum_w[W] ? MINV : MAXV;
          end else begin
            res_d = sum_w[W-1:0];
          end
          done_d = 1'b1;
        end
        kpve_pkg::OP_HALF: begin
          // halve toward zero
          res_d  = $signed(a_i + W'(a_i[W-1])) >>> 1;
          done_d = 1'b1;
        end
        kpve_pkg::OP_MUL: begin
          busy_d = 1'b1;
          neg_d  = a_i[W-1] ^ b_i[W-1];
          ma_d   = abs_a;
          mb_d   = abs_b;
          acc_d  = '0;
          cnt_d  = '0;
        end
        default: begin
          busy_d = 1'b1;
          neg_d  = a_i[W-1] ^ b_i[W-1];
          mb_d   = abs_b;
          num_d  = {1'b0, abs_a, {FRAC_BITS{1'b0}}};
          rem_d  = '0;
          quo_d  = '0;
          cnt_d  = '0;
          dz_d   = (b_i == '0);
          nz_d   = (a_i == '0);
        end
      endcase
    end else if (busy_q) begin
      if (op_q == kpve_pkg::OP_MUL) begin
        if (cnt_q == CW'(4)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          if ((prod_sh[PW-1:W] != '0) || ({1'b0, prod_sh[W-1:0]} > lim)) begin
            res_d = neg_q ? MINV : MAXV;
          end else begin
            res_d = neg_q ? (~prod_sh[W-1:0] + 1'b1) : prod_sh[W-1:0];
          end
        end else begin
          acc_d = acc_q + pp_sh;
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        // restoring division, one quotient bit per cycle
        if (cnt_q == CW'(DIVN)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          if (dz_q) begin
            res_d = nz_q ? '0 : (neg_q ? MINV : MAXV);
          end else if ((quo_q[DIVN-1:W] != '0) || ({1'b0, quo_q[W-1:0]} > lim)) begin
            res_d = neg_q ? MINV : MAXV;
          end else begin
            res_d = neg_q ? (~quo_q[W-1:0] + 1'b1) : quo_q[W-1:0];
          end
        end else begin
          num_d = num_q << 1;
          if (rem_sh >= {1'b0, mb_q}) begin
            rem_d = rem_sh - {1'b0, mb_q};
            quo_d = {quo_q[DIVN-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[DIVN-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= kpve_pkg::OP_ADD;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    dz_q  <= dz_d;
    nz_q  <= nz_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
